### rtl/core/gic_pkg.sv
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants of the gamepad input conditioner
// Payload structs, configuration record, device kinds, button bit positions,
// translated key codes and configuration register indexes.
// ----------------------------------------------------------------------------
package gic_pkg;

  // Device kinds
  localparam logic [2:0] DEV_OTHER   = 3'd0;
  localparam logic [2:0] DEV_STOCK   = 3'd1;
  localparam logic [2:0] DEV_ARCADE  = 3'd2;
  localparam logic [2:0] DEV_FISHING = 3'd3;
  localparam logic [2:0] DEV_MARACAS = 3'd4;
  localparam logic [2:0] DEV_KEYBOARD = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_DEVICE_KIND   = 3'd0;
  localparam logic [2:0] REG_TRIG_THRESH   = 3'd1;
  localparam logic [2:0] REG_MARACAS_DZ    = 3'd2;
  localparam logic [2:0] REG_FISHING_DZ    = 3'd3;
  localparam logic [2:0] REG_PULSE_LEVEL   = 3'd4;
  localparam logic [2:0] REG_LOST_LIMIT    = 3'd5;

  // Button bit positions
  localparam int unsigned BIT_C     = 0;
  localparam int unsigned BIT_B     = 1;
  localparam int unsigned BIT_A     = 2;
  localparam int unsigned BIT_START = 3;
  localparam int unsigned BIT_UP    = 4;
  localparam int unsigned BIT_DOWN  = 5;
  localparam int unsigned BIT_LEFT  = 6;
  localparam int unsigned BIT_RIGHT = 7;
  localparam int unsigned BIT_Z     = 8;
  localparam int unsigned BIT_Y     = 9;
  localparam int unsigned BIT_X     = 10;
  localparam int unsigned BIT_D     = 11;

  // Translated key codes
  localparam logic [15:0] KEY_UP      = 16'h5200;
  localparam logic [15:0] KEY_DOWN    = 16'h5100;
  localparam logic [15:0] KEY_LEFT    = 16'h5000;
  localparam logic [15:0] KEY_RIGHT   = 16'h4F00;
  localparam logic [15:0] KEY_LOWER_Z = 16'h007A;
  localparam logic [15:0] KEY_LOWER_X = 16'h0078;
  localparam logic [15:0] KEY_LOWER_A = 16'h0061;
  localparam logic [15:0] KEY_LOWER_S = 16'h0073;
  localparam logic [15:0] KEY_LOWER_Q = 16'h0071;
  localparam logic [15:0] KEY_LOWER_W = 16'h0077;
  localparam logic [15:0] KEY_ESCAPE  = 16'h001B;
  localparam logic [15:0] KEY_ENTER   = 16'h000A;

  localparam logic [7:0] LOST_MAX = 8'hFF;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef struct packed {
    logic [15:0]        raw_buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [7:0]  stick_x;
    logic signed [7:0]  stick_y;
    logic signed [7:0]  stick2_x;
    logic signed [7:0]  stick2_y;
    logic               key_valid;
    logic [15:0]        key_code;
  } item_t;

  typedef struct packed {
    logic [15:0]        buttons_out;
    logic signed [7:0]  stick_x_out;
    logic signed [7:0]  stick_y_out;
    logic [15:0]        newly_pressed;
    logic               activity;
  } result_t;

  typedef struct packed {
    logic [2:0] device_kind;
    logic [7:0] trigger_threshold;
    logic [6:0] maracas_dead_zone;
    logic [6:0] fishing_dead_zone;
    logic [6:0] maracas_pulse_level;
    logic [7:0] maracas_lost_limit;
  } cfg_t;

endpackage

### rtl/core/gamepad_input_conditioner.sv
// ----------------------------------------------------------------------------
// gamepad_input_conditioner: conditions polled controller frames
// Device-dependent button mapping, maracas axis pulsing, edge and activity
// detection, behind a two-register stream pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one polled frame per request (key_valid in tuser), m_axis
//   one conditioned result per frame. Both use tvalid/tready handshakes.
//   A frame is captured into an input register, mapped in one pass of short
//   logic and written to a result register, which drives m_axis_tvalid and
//   m_axis_tdata. One frame is taken every cycle while m_axis_tready stays
//   high; the state (previous button word, run counters, lost count)
//   updates as a frame moves from the input register to the result
//   register.
//   When the receiver stalls, the result register holds, then the input
//   register fills, and s_axis_tready drops until m_axis_tready returns.
//   The cfg channel is always ready; write it only while no frame is in
//   flight. Writing the device kind clears the stored button word.
//   Reset empties both registers, clears all state and loads the register
//   defaults (kind other, threshold 5, dead zones 20 and 60, level 120,
//   lost limit 30).
// ----------------------------------------------------------------------------
module gamepad_input_conditioner #(
  parameter int unsigned PULSE_PERIOD = 9,
  parameter int unsigned RUN_WRAP     = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // raw_buttons[15:0], left_trigger[23:16], right_trigger[31:24], stick_x[39:32],
  // stick_y[47:40], stick2_x[55:48], stick2_y[63:56], key_code[79:64]
  input  logic [gic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // key_valid[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // buttons_out[15:0], stick_x_out[23:16], stick_y_out[31:24],
  // newly_pressed[47:32], activity[48], zero[55:49]
  output logic [gic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  import gic_pkg::*;

  cfg_t    cfg_q;
  item_t   in_item_d, in_item_q;
  result_t res_d, res_q;
  logic    in_valid_q, out_valid_q;
  logic    advance, cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_item_d.raw_buttons   = s_axis_tdata[15:0];
    in_item_d.left_trigger  = s_axis_tdata[23:16];
    in_item_d.right_trigger = s_axis_tdata[31:24];
    in_item_d.stick_x       = $signed(s_axis_tdata[39:32]);
    in_item_d.stick_y       = $signed(s_axis_tdata[47:40]);
    in_item_d.stick2_x      = $signed(s_axis_tdata[55:48]);
    in_item_d.stick2_y      = $signed(s_axis_tdata[63:56]);
    in_item_d.key_valid     = s_axis_tuser;
    in_item_d.key_code      = s_axis_tdata[79:64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_kind         <= DEV_OTHER;
      cfg_q.trigger_threshold   <= 8'd5;
      cfg_q.maracas_dead_zone   <= 7'd20;
      cfg_q.fishing_dead_zone   <= 7'd60;
      cfg_q.maracas_pulse_level <= 7'd120;
      cfg_q.maracas_lost_limit  <= 8'd30;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_DEVICE_KIND: cfg_q.device_kind         <= cfg_data_i[2:0];
        REG_TRIG_THRESH: cfg_q.trigger_threshold   <= cfg_data_i;
        REG_MARACAS_DZ:  cfg_q.maracas_dead_zone   <= cfg_data_i[6:0];
        REG_FISHING_DZ:  cfg_q.fishing_dead_zone   <= cfg_data_i[6:0];
        REG_PULSE_LEVEL: cfg_q.maracas_pulse_level <= cfg_data_i[6:0];
        REG_LOST_LIMIT:  cfg_q.maracas_lost_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gic_core #(
    .PULSE_PERIOD (PULSE_PERIOD),
    .RUN_WRAP     (RUN_WRAP)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .clear_prev_i (cfg_we && (cfg_index_i == REG_DEVICE_KIND)),
    .item_i       (in_item_q),
    .cfg_i        (cfg_q),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers: load on capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_item_q <= in_item_d;
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.activity, res_q.newly_pressed,
                          res_q.stick_y_out, res_q.stick_x_out, res_q.buttons_out};

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while both pipeline registers are full");

  a_result_leaves_on_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(m_axis_tready))
    else $error("result dropped without a completed request");

  a_no_silent_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(res_q) || $past(advance) == 1'b0)
    else $error("stalled result register overwritten");

endmodule

### rtl/core/gic_axis.sv
// ----------------------------------------------------------------------------
// gic_axis: pulsed dead-zone conditioning of one maracas stick axis
// Holds the negative and positive run counters of the axis, each with a
// running phase modulo the pulse period, and gives the pulsed axis value.
// ----------------------------------------------------------------------------
module gic_axis #(
  parameter int unsigned PULSE_PERIOD = 9,
  parameter int unsigned RUN_WRAP     = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic signed [7:0] value_i,
  input  logic [6:0]        dead_zone_i,
  input  logic [6:0]        level_i,
  output logic signed [7:0] value_o
);

  localparam int unsigned PhW = $clog2(PULSE_PERIOD);
  localparam logic [PhW-1:0] PhLast = PhW'(PULSE_PERIOD - 1);
  localparam logic [PhW-1:0] PhOne  = PhW'(1);
  localparam logic [7:0] Wrap = 8'(RUN_WRAP);

  logic [7:0]     neg_q, neg_d, pos_q, pos_d;
  logic [PhW-1:0] neg_ph_q, neg_ph_d, pos_ph_q, pos_ph_d;
  logic [7:0]     neg_adv, pos_adv;
  logic [PhW-1:0] neg_ph_adv, pos_ph_adv;
  logic signed [8:0] v_ext, dz_ext;
  logic below, above;
  logic signed [7:0] neg_level, pos_level;

  assign v_ext     = $signed({value_i[7], value_i});
  assign dz_ext    = $signed({2'b00, dead_zone_i});
  assign below     = v_ext < -dz_ext;
  assign above     = v_ext > dz_ext;
  assign pos_level = $signed({1'b0, level_i});
  assign neg_level = $signed(8'd0 - {1'b0, level_i});

  // Advance a run counter; wrap past the limit back to one
  always_comb begin
    if (neg_q >= Wrap) begin
      neg_adv    = 8'd1;
      neg_ph_adv = PhOne;
    end else begin
      neg_adv    = neg_q + 8'd1;
      neg_ph_adv = (neg_ph_q == PhLast) ? '0 : neg_ph_q + PhOne;
    end
    if (pos_q >= Wrap) begin
      pos_adv    = 8'd1;
      pos_ph_adv = PhOne;
    end else begin
      pos_adv    = pos_q + 8'd1;
      pos_ph_adv = (pos_ph_q == PhLast) ? '0 : pos_ph_q + PhOne;
    end
  end

  always_comb begin
    neg_d    = neg_q;
    neg_ph_d = neg_ph_q;
    pos_d    = pos_q;
    pos_ph_d = pos_ph_q;
    value_o  = 8'sd0;
    if (below) begin
      neg_d    = neg_adv;
      neg_ph_d = neg_ph_adv;
      pos_d    = '0;
      pos_ph_d = '0;
      value_o  = (neg_ph_adv != '0) ? neg_level : 8'sd0;
    end else if (above) begin
      neg_d    = '0;
      neg_ph_d = '0;
      pos_d    = pos_adv;
      pos_ph_d = pos_ph_adv;
      value_o  = (pos_ph_adv != '0) ? pos_level : 8'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q    <= '0;
      neg_ph_q <= '0;
      pos_q    <= '0;
      pos_ph_q <= '0;
    end else if (en_i) begin
      neg_q    <= neg_d;
      neg_ph_q <= neg_ph_d;
      pos_q    <= pos_d;
      pos_ph_q <= pos_ph_d;
    end
  end

  a_one_side_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(neg_q != 8'd0 && pos_q != 8'd0))
    else $error("both run counters of one axis are active");

  a_wrap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && below && neg_q == Wrap) |=> (neg_q == 8'd1 && neg_ph_q == PhOne))
    else $error("negative run counter did not wrap to one");

endmodule

### rtl/core/gic_core.sv
// ----------------------------------------------------------------------------
// gic_core: per-frame device mapping and frame-to-frame state
// Maps the raw frame to the conditioned button word and axes for the
// configured device kind, tracks the previous word and the lost-maraca count.
// ----------------------------------------------------------------------------
module gic_core #(
  parameter int unsigned PULSE_PERIOD = 9,
  parameter int unsigned RUN_WRAP     = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             clear_prev_i,
  input  gic_pkg::item_t   item_i,
  input  gic_pkg::cfg_t    cfg_i,
  output gic_pkg::result_t result_o
);

  import gic_pkg::*;

  logic [15:0] prev_q, prev_d;
  logic [7:0]  lost_q, lost_d;
  logic [15:0] btn;
  logic        is_maracas, zero_axes;
  logic signed [7:0] ax_x_in, ax_y_in, ax_x_out, ax_y_out;
  logic signed [8:0] x2_ext, y2_ext, fdz_ext;

  assign is_maracas = (cfg_i.device_kind == DEV_MARACAS);
  assign x2_ext  = $signed({item_i.stick2_x[7], item_i.stick2_x});
  assign y2_ext  = $signed({item_i.stick2_y[7], item_i.stick2_y});
  assign fdz_ext = $signed({2'b00, cfg_i.fishing_dead_zone});

  // Lost-maraca count: saturate while Z is held, clear otherwise
  always_comb begin
    if (item_i.raw_buttons[BIT_Z]) begin
      lost_d = (lost_q == LOST_MAX) ? LOST_MAX : lost_q + 8'd1;
    end else begin
      lost_d = '0;
    end
  end
  assign zero_axes = item_i.raw_buttons[BIT_Z] && (lost_d > cfg_i.maracas_lost_limit);
  assign ax_x_in   = zero_axes ? 8'sd0 : item_i.stick_x;
  assign ax_y_in   = zero_axes ? 8'sd0 : item_i.stick_y;

  gic_axis #(
    .PULSE_PERIOD (PULSE_PERIOD),
    .RUN_WRAP     (RUN_WRAP)
  ) u_axis_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_i && is_maracas),
    .value_i     (ax_y_in),
    .dead_zone_i (cfg_i.maracas_dead_zone),
    .level_i     (cfg_i.maracas_pulse_level),
    .value_o     (ax_y_out)
  );

  gic_axis #(
    .PULSE_PERIOD (PULSE_PERIOD),
    .RUN_WRAP     (RUN_WRAP)
  ) u_axis_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_i && is_maracas),
    .value_i     (ax_x_in),
    .dead_zone_i (cfg_i.maracas_dead_zone),
    .level_i     (cfg_i.maracas_pulse_level),
    .value_o     (ax_x_out)
  );

  always_comb begin
    btn = item_i.raw_buttons;
    case (cfg_i.device_kind)
      DEV_STOCK: begin
        if (item_i.left_trigger > cfg_i.trigger_threshold) btn[BIT_Z] = 1'b1;
        if (item_i.right_trigger > cfg_i.trigger_threshold) btn[BIT_D] = 1'b1;
      end
      DEV_ARCADE: begin
        // Z is already the left trigger bit; only C needs copying
        if (item_i.raw_buttons[BIT_C]) btn[BIT_D] = 1'b1;
      end
      DEV_FISHING: begin
        if (y2_ext < -fdz_ext) btn[BIT_UP] = 1'b1;
        else if (y2_ext > fdz_ext) btn[BIT_DOWN] = 1'b1;
        if (x2_ext < -fdz_ext) btn[BIT_LEFT] = 1'b1;
        else if (x2_ext > fdz_ext) btn[BIT_RIGHT] = 1'b1;
      end
      DEV_KEYBOARD: begin
        if (item_i.key_valid) begin
          case (item_i.key_code)
            KEY_UP:      btn[BIT_UP]    = 1'b1;
            KEY_DOWN:    btn[BIT_DOWN]  = 1'b1;
            KEY_LEFT:    btn[BIT_LEFT]  = 1'b1;
            KEY_RIGHT:   btn[BIT_RIGHT] = 1'b1;
            KEY_LOWER_Z: btn[BIT_A]     = 1'b1;
            KEY_LOWER_X: btn[BIT_B]     = 1'b1;
            KEY_LOWER_A: btn[BIT_X]     = 1'b1;
            KEY_LOWER_S: btn[BIT_Y]     = 1'b1;
            KEY_LOWER_Q: btn[BIT_Z]     = 1'b1;
            KEY_LOWER_W: btn[BIT_D]     = 1'b1;
            KEY_ESCAPE:  btn[BIT_B]     = 1'b1;
            KEY_ENTER:   btn[BIT_START] = 1'b1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.buttons_out   = btn;
    result_o.stick_x_out   = is_maracas ? ax_x_out : item_i.stick_x;
    result_o.stick_y_out   = is_maracas ? ax_y_out : item_i.stick_y;
    result_o.newly_pressed = btn & ~prev_q;
    result_o.activity      = (btn != prev_q);
  end

  always_comb begin
    prev_d = prev_q;
    if (clear_prev_i) prev_d = '0;
    else if (en_i) prev_d = btn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      lost_q <= '0;
    end else begin
      prev_q <= prev_d;
      if (en_i && is_maracas) lost_q <= lost_d;
    end
  end

  a_lost_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && is_maracas && item_i.raw_buttons[BIT_Z] && lost_q == LOST_MAX)
      |=> (lost_q == LOST_MAX))
    else $error("lost-maraca count left saturation while Z held");

endmodule
